// ===== rtl/multibulk_request_deframer_core_defines.svh =====
// Assertion macros used by the checker.
`ifndef MULTIBULK_REQUEST_DEFRAMER_CORE_DEFINES_SVH
`define MULTIBULK_REQUEST_DEFRAMER_CORE_DEFINES_SVH

// Clocked on clk, disabled while arst_n is low.
`define MRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MRD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`MRD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/mrd_pkg.sv =====
package mrd_pkg;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;
	localparam int INDEX_W = 20;
	localparam int ECODE_W = 3;
	localparam int COUNT_W = 21;
	localparam int NUM_W   = 32;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DATA_W  = 56;

	// phases
	localparam logic [PHASE_W-1:0] PH_STAR    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DOLLAR  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CR      = 3'd5;
	localparam logic [PHASE_W-1:0] PH_LF      = 3'd6;

	// event kinds
	localparam logic [KIND_W-1:0] EV_NONE  = 3'd0;
	localparam logic [KIND_W-1:0] EV_BYTE  = 3'd1;
	localparam logic [KIND_W-1:0] EV_EMPTY = 3'd2;
	localparam logic [KIND_W-1:0] EV_DONE  = 3'd3;
	localparam logic [KIND_W-1:0] EV_ERROR = 3'd4;

	// error codes
	localparam logic [ECODE_W-1:0] ERR_BAD_STAR     = 3'd0;
	localparam logic [ECODE_W-1:0] ERR_COUNT_LONG   = 3'd1;
	localparam logic [ECODE_W-1:0] ERR_BAD_COUNT    = 3'd2;
	localparam logic [ECODE_W-1:0] ERR_NO_DOLLAR    = 3'd3;
	localparam logic [ECODE_W-1:0] ERR_LENGTH_LONG  = 3'd4;
	localparam logic [ECODE_W-1:0] ERR_BAD_LENGTH   = 3'd5;
	localparam logic [ECODE_W-1:0] ERR_LEN_MISMATCH = 3'd6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ARG_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_BYTES  = 2'd2;

	localparam logic [COUNT_W-1:0] MAX_ARG_COUNT_RST   = 21'd1048576;
	localparam logic [NUM_W-1:0]   MAX_BULK_LENGTH_RST = 32'd536870912;
	localparam logic [COUNT_W-1:0] MAX_LINE_BYTES_RST  = 21'd65536;
	localparam logic [COUNT_W-1:0] LINE_CNT_MAX        = '1;

	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic [COUNT_W-1:0] max_arg_count;
		logic [NUM_W-1:0]   max_bulk_length;
		logic [COUNT_W-1:0] max_line_bytes;
	} mrd_cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [NUM_W-1:0]   acc;
		logic               digits_ended;
		logic               minus_seen;
		logic               saw_cr;
		logic [COUNT_W-1:0] line_cnt;
		logic [COUNT_W-1:0] args_expected;
		logic [COUNT_W-1:0] current_arg;
		logic [NUM_W-1:0]   remaining;
		logic               err;
	} mrd_state_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  arg_byte;
		logic [INDEX_W-1:0] arg_index;
		logic               arg_last_byte;
		logic [ECODE_W-1:0] error_code;
		logic [COUNT_W-1:0] arg_total;
	} mrd_result_t;

endpackage

// ===== rtl/multibulk_request_deframer_core.sv =====
// A byte taken on s_* passes through the input register (byte_s1) and then the
// result register (res_s2) before its event shows on m_*.
// Throughput: one byte per cycle; every byte yields exactly one event; a stall
// on m_tready holds the result register and then the input register.
// arst_n clears the state to wait-for-star, empties both registers and
// restores the limit registers to their defaults.
module multibulk_request_deframer_core
	import mrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] byte_in
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_W-1:0]     m_tdata,    // [7:0] arg_byte, [27:8] arg_index,
	                                          // [30:28] error_code, [51:31] arg_total
	output logic [KIND_W-1:0]     m_tuser,    // [2:0] event_kind
	output logic                  m_tlast,    // arg_last_byte
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	mrd_cfg_t          cfg;
	mrd_state_t        state_q;
	mrd_state_t        state_nxt;
	mrd_result_t       res;
	mrd_result_t       res_s2;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	mrd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mrd_step u_step (
		.cfg     (cfg),
		.cur     (state_q),
		.byte_in (byte_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{phase: PH_STAR, default: '0};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.arg_total, res_s2.error_code, res_s2.arg_index,
		res_s2.arg_byte};
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.arg_last_byte;

endmodule

// ===== rtl/mrd_cfg.sv =====
module mrd_cfg
	import mrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output mrd_cfg_t              cfg
);

	mrd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_arg_count   <= MAX_ARG_COUNT_RST;
			cfg_q.max_bulk_length <= MAX_BULK_LENGTH_RST;
			cfg_q.max_line_bytes  <= MAX_LINE_BYTES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_ARG_COUNT:   cfg_q.max_arg_count   <= cfg_data[COUNT_W-1:0];
				REG_MAX_BULK_LENGTH: cfg_q.max_bulk_length <= cfg_data[NUM_W-1:0];
				REG_MAX_LINE_BYTES:  cfg_q.max_line_bytes  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/mrd_step.sv =====
module mrd_step
	import mrd_pkg::*;
(
	input  mrd_cfg_t          cfg,
	input  mrd_state_t        cur,
	input  logic [BYTE_W-1:0] byte_in,
	output mrd_state_t        nxt,
	output mrd_result_t       res
);

	logic               is_digit;
	logic               line_first;
	logic               line_end;
	logic [NUM_W+3:0]   prod;
	logic [NUM_W-1:0]   acc_next;
	logic [COUNT_W-1:0] line_cnt_inc;
	logic [COUNT_W-1:0] arg_inc;
	logic [NUM_W-1:0]   rem_dec;

	assign is_digit   = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign line_first = (cur.line_cnt == '0);
	assign line_end   = cur.saw_cr && (byte_in == CH_LF);
	// acc*10 + digit, saturating at all ones
	assign prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
		+ {32'd0, byte_in[3:0]};
	assign acc_next = (prod[NUM_W+3:NUM_W] != '0) ? '1 : prod[NUM_W-1:0];
	assign line_cnt_inc = (cur.line_cnt != LINE_CNT_MAX) ? cur.line_cnt + 1'b1 : cur.line_cnt;
	assign arg_inc = cur.current_arg + 1'b1;
	assign rem_dec = (cur.remaining != '0) ? cur.remaining - 1'b1 : cur.remaining;

	always_comb begin
		nxt = cur;
		res = '0;
		if (!cur.err) begin
			case (cur.phase)
				PH_STAR: begin
					if (byte_in == CH_STAR) begin
						nxt.acc = '0;
						nxt.digits_ended = 1'b0;
						nxt.minus_seen = 1'b0;
						nxt.saw_cr = 1'b0;
						nxt.line_cnt = '0;
						nxt.phase = PH_COUNT;
					end else begin
						res.kind = EV_ERROR;
						res.error_code = ERR_BAD_STAR;
					end
				end
				PH_DOLLAR: begin
					if (byte_in == CH_DOLLAR) begin
						nxt.acc = '0;
						nxt.digits_ended = 1'b0;
						nxt.minus_seen = 1'b0;
						nxt.saw_cr = 1'b0;
						nxt.line_cnt = '0;
						nxt.phase = PH_LENGTH;
					end else begin
						res.kind = EV_ERROR;
						res.error_code = ERR_NO_DOLLAR;
					end
				end
				PH_COUNT, PH_LENGTH: begin
					if (line_end) begin
						if (cur.phase == PH_COUNT) begin
							if (cur.minus_seen || (cur.acc > {11'd0, cfg.max_arg_count})) begin
								res.kind = EV_ERROR;
								res.error_code = ERR_BAD_COUNT;
							end else begin
								nxt.args_expected = cur.acc[COUNT_W-1:0];
								nxt.current_arg = '0;
								if (cur.acc[COUNT_W-1:0] == '0) begin
									res.kind = EV_DONE;
									nxt.phase = PH_STAR;
								end else begin
									nxt.phase = PH_DOLLAR;
								end
							end
						end else begin
							if (cur.minus_seen || (cur.acc > cfg.max_bulk_length)) begin
								res.kind = EV_ERROR;
								res.error_code = ERR_BAD_LENGTH;
							end else begin
								nxt.remaining = cur.acc;
								if (cur.acc == '0) begin
									res.kind = EV_EMPTY;
									res.arg_index = cur.current_arg[INDEX_W-1:0];
									nxt.phase = PH_CR;
								end else begin
									nxt.phase = PH_PAYLOAD;
								end
							end
						end
						nxt.acc = '0;
						nxt.digits_ended = 1'b0;
						nxt.minus_seen = 1'b0;
						nxt.saw_cr = 1'b0;
						nxt.line_cnt = '0;
					end else begin
						if (!cur.digits_ended) begin
							if (is_digit) begin
								nxt.acc = acc_next;
							end else if (line_first && (byte_in == CH_MINUS)) begin
								nxt.minus_seen = 1'b1;
							end else if (!(line_first && (byte_in == CH_PLUS))) begin
								nxt.digits_ended = 1'b1;
							end
						end
						nxt.saw_cr = (byte_in == CH_CR);
						nxt.line_cnt = line_cnt_inc;
						if (line_cnt_inc > cfg.max_line_bytes) begin
							res.kind = EV_ERROR;
							res.error_code = (cur.phase == PH_COUNT) ? ERR_COUNT_LONG
								: ERR_LENGTH_LONG;
						end
					end
				end
				PH_PAYLOAD: begin
					res.kind = EV_BYTE;
					res.arg_byte = byte_in;
					res.arg_index = cur.current_arg[INDEX_W-1:0];
					res.arg_last_byte = (cur.remaining <= 32'd1);
					nxt.remaining = rem_dec;
					if (rem_dec == '0) begin
						nxt.phase = PH_CR;
					end
				end
				PH_CR: begin
					if (byte_in == CH_CR) begin
						nxt.phase = PH_LF;
					end else begin
						res.kind = EV_ERROR;
						res.error_code = ERR_LEN_MISMATCH;
					end
				end
				PH_LF: begin
					if (byte_in == CH_LF) begin
						if (arg_inc >= cur.args_expected) begin
							res.kind = EV_DONE;
							res.arg_total = cur.args_expected;
							nxt.current_arg = '0;
							nxt.phase = PH_STAR;
						end else begin
							nxt.current_arg = arg_inc;
							nxt.phase = PH_DOLLAR;
						end
					end else begin
						res.kind = EV_ERROR;
						res.error_code = ERR_LEN_MISMATCH;
					end
				end
				default: begin
					nxt.phase = PH_STAR;
				end
			endcase
			if (res.kind == EV_ERROR) begin
				nxt.err = 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mrd_checker.sv =====
`include "multibulk_request_deframer_core_defines.svh"

module mrd_checker
	import mrd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0] m_tuser,
	input logic              m_tlast
);

	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && (m_tuser == EV_ERROR)) begin
			err_seen_q <= 1'b1;
		end
	end

	`MRD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output transaction changed")
	`MRD_ASSERT_IMPLY(a_silent_after_error, m_tvalid && err_seen_q, (m_tuser == EV_NONE) && (m_tdata == '0) && !m_tlast, "event after error")
	`MRD_ASSERT_IMPLY(a_last_on_byte, m_tvalid && m_tlast, m_tuser == EV_BYTE, "last mark outside argument byte")
	`MRD_ASSERT_IMPLY(a_done_fields, m_tvalid && (m_tuser == EV_DONE), m_tdata[30:0] == '0, "request complete carries byte, index or code")

endmodule

bind multibulk_request_deframer_core mrd_checker u_mrd_checker (.*);

// ===== test/tb_multibulk_request_deframer_core.sv =====
module tb_multibulk_request_deframer_core;
	import mrd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOW_PCT = 77;
	localparam int MIX_PCT  = 17;

	typedef enum logic [1:0] {FLOW_FULL, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [DATA_W-1:0]     m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	multibulk_request_deframer_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// parser mirror
	logic [COUNT_W-1:0] lim_args = MAX_ARG_COUNT_RST;
	logic [NUM_W-1:0]   lim_bulk = MAX_BULK_LENGTH_RST;
	logic [COUNT_W-1:0] lim_line = MAX_LINE_BYTES_RST;

	logic [PHASE_W-1:0] rq_phase = PH_STAR;
	logic [NUM_W-1:0]   rq_acc = '0;
	logic               rq_digits_done = 1'b0;
	logic               rq_minus = 1'b0;
	logic               rq_cr = 1'b0;
	logic [COUNT_W-1:0] rq_line_len = '0;
	logic [COUNT_W-1:0] rq_args = '0;
	logic [COUNT_W-1:0] rq_arg = '0;
	logic [NUM_W-1:0]   rq_left = '0;
	logic               rq_dead = 1'b0;

	logic [BYTE_W-1:0] tx_bytes[$];
	mrd_result_t       event_q[$];
	int unsigned       tx_total = 0;
	int unsigned       tx_accepted = 0;
	bit                tx_fired = 1'b0;
	flow_t             flow = FLOW_FULL;
	int unsigned       mismatches = 0;
	mrd_result_t       seen_ev;
	mrd_result_t       want_ev;

	function automatic void restart_line();
		rq_acc = '0;
		rq_digits_done = 1'b0;
		rq_minus = 1'b0;
		rq_cr = 1'b0;
		rq_line_len = '0;
	endfunction

	function automatic mrd_result_t deframe_byte(logic [BYTE_W-1:0] b);
		mrd_result_t ev;
		logic [63:0] prod;
		ev = '0;
		if (!rq_dead) begin
			case (rq_phase)
			PH_STAR: begin
				if (b == CH_STAR) begin
					restart_line();
					rq_phase = PH_COUNT;
				end else begin
					ev.kind = EV_ERROR;
					ev.error_code = ERR_BAD_STAR;
				end
			end
			PH_DOLLAR: begin
				if (b == CH_DOLLAR) begin
					restart_line();
					rq_phase = PH_LENGTH;
				end else begin
					ev.kind = EV_ERROR;
					ev.error_code = ERR_NO_DOLLAR;
				end
			end
			PH_COUNT, PH_LENGTH: begin
				if (rq_cr && b == CH_LF) begin
					if (rq_phase == PH_COUNT) begin
						if (rq_minus || rq_acc > lim_args) begin
							ev.kind = EV_ERROR;
							ev.error_code = ERR_BAD_COUNT;
						end else begin
							rq_args = rq_acc[COUNT_W-1:0];
							rq_arg = '0;
							if (rq_args == 0) begin
								ev.kind = EV_DONE;
								rq_phase = PH_STAR;
							end else
								rq_phase = PH_DOLLAR;
						end
					end else begin
						if (rq_minus || rq_acc > lim_bulk) begin
							ev.kind = EV_ERROR;
							ev.error_code = ERR_BAD_LENGTH;
						end else begin
							rq_left = rq_acc;
							if (rq_left == 0) begin
								ev.kind = EV_EMPTY;
								ev.arg_index = rq_arg[INDEX_W-1:0];
								rq_phase = PH_CR;
							end else
								rq_phase = PH_PAYLOAD;
						end
					end
					restart_line();
				end else begin
					if (!rq_digits_done) begin
						if (b >= CH_ZERO && b <= CH_NINE) begin
							prod = 64'(rq_acc) * 64'd10 + 64'(b - CH_ZERO);
							rq_acc = (prod > 64'hFFFF_FFFF) ? '1 : prod[NUM_W-1:0];
						end else if (rq_line_len == 0 && b == CH_MINUS)
							rq_minus = 1'b1;
						else if (!(rq_line_len == 0 && b == CH_PLUS))
							rq_digits_done = 1'b1;
					end
					rq_cr = (b == CH_CR);
					if (rq_line_len != LINE_CNT_MAX)
						rq_line_len++;
					if (rq_line_len > lim_line) begin
						ev.kind = EV_ERROR;
						ev.error_code = (rq_phase == PH_COUNT) ? ERR_COUNT_LONG : ERR_LENGTH_LONG;
					end
				end
			end
			PH_PAYLOAD: begin
				ev.kind = EV_BYTE;
				ev.arg_byte = b;
				ev.arg_index = rq_arg[INDEX_W-1:0];
				ev.arg_last_byte = (rq_left <= 1);
				if (rq_left != 0)
					rq_left--;
				if (rq_left == 0)
					rq_phase = PH_CR;
			end
			PH_CR: begin
				if (b == CH_CR)
					rq_phase = PH_LF;
				else begin
					ev.kind = EV_ERROR;
					ev.error_code = ERR_LEN_MISMATCH;
				end
			end
			PH_LF: begin
				if (b == CH_LF) begin
					rq_arg = rq_arg + 1'b1;
					if (rq_arg >= rq_args) begin
						ev.kind = EV_DONE;
						ev.arg_total = rq_args;
						rq_arg = '0;
						rq_phase = PH_STAR;
					end else
						rq_phase = PH_DOLLAR;
				end else begin
					ev.kind = EV_ERROR;
					ev.error_code = ERR_LEN_MISMATCH;
				end
			end
			default: rq_phase = PH_STAR;
			endcase
			if (ev.kind == EV_ERROR)
				rq_dead = 1'b1;
		end
		return ev;
	endfunction

	function automatic string show_event(mrd_result_t ev);
		return $sformatf("kind=%0d byte=%02h index=%0d last=%0b code=%0d total=%0d",
			ev.kind, ev.arg_byte, ev.arg_index, ev.arg_last_byte, ev.error_code, ev.arg_total);
	endfunction

	function automatic int unsigned umin(int unsigned a, int unsigned b2);
		return (a < b2) ? a : b2;
	endfunction

	// largest all-nines value of at most nine digits whose decimal line still fits the line limit
	function automatic int unsigned line_value_cap();
		int unsigned c;
		c = 0;
		for (int i = 1; i < lim_line && i < 10; i++)
			c = c * 10 + 9;
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("multibulk_request_deframer_core verification failed");
		$finish;
	end

	// input transactions
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			event_q.insert(event_q.size(), deframe_byte(s_tdata));
			tx_accepted++;
			tx_fired = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || tx_fired)) begin
			tx_fired = 1'b0;
			if (tx_bytes.size() != 0 && $urandom_range(99) >=
				((flow == FLOW_SRC_IDLE) ? SLOW_PCT : (flow == FLOW_BOTH) ? MIX_PCT : 0)) begin
				s_tdata <= tx_bytes.pop_front();
				s_tvalid <= 1'b1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		m_tready <= $urandom_range(99) >=
			((flow == FLOW_SINK_STALL) ? SLOW_PCT : (flow == FLOW_BOTH) ? MIX_PCT : 0);
	end

	// output transactions
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_ev.kind = m_tuser;
			seen_ev.arg_byte = m_tdata[7:0];
			seen_ev.arg_index = m_tdata[27:8];
			seen_ev.arg_last_byte = m_tlast;
			seen_ev.error_code = m_tdata[30:28];
			seen_ev.arg_total = m_tdata[51:31];
			if (event_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event at %0t: %s", $time, show_event(seen_ev));
			end else begin
				want_ev = event_q.pop_front();
				if (seen_ev !== want_ev) begin
					mismatches++;
					if (mismatches <= 10)
						$display("event mismatch at %0t: expected %s, got %s", $time,
							show_event(want_ev), show_event(seen_ev));
				end
			end
		end
	end

	task automatic push_byte(logic [BYTE_W-1:0] b);
		tx_bytes.insert(tx_bytes.size(), b);
		tx_total++;
	endtask

	task automatic push_crlf();
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic push_text(string s);
		foreach (s[i])
			push_byte(s[i]);
	endtask

	task automatic push_number_line(logic [BYTE_W-1:0] lead, int unsigned value);
		string digits;
		logic [BYTE_W-1:0] body[$];
		int zeros;
		digits = $sformatf("%0d", value);
		if ($urandom_range(3) == 0) begin
			zeros = ($urandom_range(15) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3);
			repeat (zeros) body.insert(body.size(), CH_ZERO);
		end
		if (value != 0 || $urandom_range(2) != 0)
			foreach (digits[i]) body.insert(body.size(), digits[i]);
		if ($urandom_range(4) == 0)
			body.push_front(CH_PLUS);
		if ($urandom_range(4) == 0) begin
			body.insert(body.size(), 8'($urandom_range(8'h61, 8'h7A)));
			if ($urandom_range(1)) begin
				body.insert(body.size(), CH_CR);
				body.insert(body.size(), 8'h20);
			end
		end
		if (body.size() + 1 > lim_line) begin
			body.delete();
			if (value != 0)
				foreach (digits[i]) body.insert(body.size(), digits[i]);
		end
		push_byte(lead);
		foreach (body[i])
			push_byte(body[i]);
		push_crlf();
	endtask

	task automatic push_request(int unsigned n_hi, int unsigned len_hi);
		int unsigned cap, n, lhi, len;
		logic [BYTE_W-1:0] pb;
		cap = line_value_cap();
		n = $urandom_range(0, umin(umin(n_hi, lim_args), cap));
		push_number_line(CH_STAR, n);
		repeat (n) begin
			lhi = umin(umin(len_hi, lim_bulk), cap);
			len = ($urandom_range(9) == 0) ? $urandom_range(0, lhi) : $urandom_range(0, umin(6, lhi));
			push_number_line(CH_DOLLAR, len);
			repeat (len) begin
				if ($urandom_range(7) == 0)
					case ($urandom_range(3))
					0: pb = CH_CR;
					1: pb = CH_LF;
					2: pb = CH_STAR;
					default: pb = CH_DOLLAR;
					endcase
				else
					pb = 8'($urandom_range(255));
				push_byte(pb);
			end
			push_crlf();
		end
	endtask

	task automatic push_random_requests(int unsigned budget, int unsigned n_hi, int unsigned len_hi);
		int unsigned start;
		start = tx_total;
		while (tx_total - start < budget)
			push_request(n_hi, len_hi);
	endtask

	task automatic push_bad_number(int unsigned limit);
		case ($urandom_range(2))
		0: begin
			push_byte(CH_MINUS);
			push_byte(CH_ZERO + 8'($urandom_range(9)));
		end
		1: push_text($sformatf("%0d", limit + 1));
		default: push_text("99999999999");
		endcase
		push_crlf();
	endtask

	// one malformed request; the parser stays silent afterwards
	task automatic push_fault();
		logic [BYTE_W-1:0] b;
		case ($urandom_range(6))
		0: begin
			do b = 8'($urandom_range(255)); while (b == CH_STAR);
			push_byte(b);
		end
		1: begin
			push_byte(CH_STAR);
			repeat (lim_line + 1) push_byte(CH_ZERO + 8'($urandom_range(9)));
		end
		2: begin
			push_byte(CH_STAR);
			push_bad_number(lim_args);
		end
		3: begin
			push_number_line(CH_STAR, $urandom_range(1, lim_args));
			do b = 8'($urandom_range(255)); while (b == CH_DOLLAR);
			push_byte(b);
		end
		4: begin
			push_number_line(CH_STAR, 1);
			push_byte(CH_DOLLAR);
			repeat (lim_line + 1) push_byte(CH_ZERO + 8'($urandom_range(9)));
		end
		5: begin
			push_number_line(CH_STAR, 1);
			push_byte(CH_DOLLAR);
			push_bad_number(lim_bulk);
		end
		default: begin
			push_number_line(CH_STAR, 1);
			push_number_line(CH_DOLLAR, 1);
			push_byte(8'($urandom_range(255)));
			if ($urandom_range(1)) begin
				do b = 8'($urandom_range(255)); while (b == CH_CR);
				push_byte(b);
			end else begin
				push_byte(CH_CR);
				do b = 8'($urandom_range(255)); while (b == CH_LF);
				push_byte(b);
			end
		end
		endcase
		repeat (8) push_byte(8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (tx_accepted != tx_total || event_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_MAX_ARG_COUNT:   lim_args = val[COUNT_W-1:0];
		REG_MAX_BULK_LENGTH: lim_bulk = val;
		REG_MAX_LINE_BYTES:  lim_line = val[COUNT_W-1:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: empty count line, signed count, empty arg, binary payload
		push_byte(CH_STAR);
		push_crlf();
		push_text("*+2");
		push_crlf();
		push_text("$0");
		push_crlf();
		push_crlf();
		push_text("$3");
		push_crlf();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_crlf();
		push_random_requests(210, 4, 24);
		wait_drained();

		write_limit(REG_MAX_ARG_COUNT, 32'd1048576);
		write_limit(REG_MAX_BULK_LENGTH, '1);
		write_limit(REG_MAX_LINE_BYTES, 32'd1048576);
		flow = FLOW_SRC_IDLE;
		push_random_requests(250, 12, 64);
		wait_drained();

		write_limit(REG_MAX_ARG_COUNT, 32'd0);
		write_limit(REG_MAX_BULK_LENGTH, 32'd0);
		write_limit(REG_MAX_LINE_BYTES, 32'd1);
		flow = FLOW_BOTH;
		push_random_requests(40, 0, 0);
		wait_drained();

		write_limit(REG_MAX_ARG_COUNT, $urandom_range(1, 3));
		write_limit(REG_MAX_LINE_BYTES, 32'd2);
		flow = FLOW_SINK_STALL;
		push_random_requests(170, 9, 0);
		wait_drained();

		write_limit(REG_MAX_ARG_COUNT, $urandom_range(1, 6));
		write_limit(REG_MAX_BULK_LENGTH, $urandom_range(1, 16));
		write_limit(REG_MAX_LINE_BYTES, $urandom_range(12, 20));
		flow = FLOW_BOTH;
		push_random_requests(250, 6, 16);
		push_fault();
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("multibulk_request_deframer_core verification clean");
		else
			$display("multibulk_request_deframer_core verification failed");
		$finish;
	end

endmodule
